/* design/positional_linked_list_macros.svh */
// Assertion macros shared by the list controller and datapath.
// Each one samples on the rising edge of i_clk and is off while i_rst_n is low.
`ifndef POSITIONAL_LINKED_LIST_MACROS_SVH
`define POSITIONAL_LINKED_LIST_MACROS_SVH

// A property that must hold at every clock edge.
`define PLL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define PLL_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* design/pll_pkg.sv */
package pll_pkg;

    // Field widths of the request and result items.
    localparam int FUNC_W     = 3;
    localparam int POS_W      = 8;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int LEN_W      = 7;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;

    // Operation codes carried by a request.
    localparam logic [FUNC_W-1:0] FUNC_INS_HEAD = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_INS_TAIL = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_INS_POS  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_DELETE   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_READ_ALL = 3'd4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_POS = 2'd3;

    // List update actions that the datapath carries out.
    localparam int ACT_W = 3;
    localparam logic [ACT_W-1:0] ACT_NONE     = 3'd0;
    localparam logic [ACT_W-1:0] ACT_INS_HEAD = 3'd1;
    localparam logic [ACT_W-1:0] ACT_INS_TAIL = 3'd2;
    localparam logic [ACT_W-1:0] ACT_MID_NEW  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_MID_LINK = 3'd4;
    localparam logic [ACT_W-1:0] ACT_DEL_HEAD = 3'd5;
    localparam logic [ACT_W-1:0] ACT_DEL_MID  = 3'd6;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                load_req;
        logic                walk_start;
        logic                tgt_minus1;
        logic                advance;
        logic [ACT_W-1:0]    act;
        logic                emit_elem;
        logic                emit_res;
        logic [STATUS_W-1:0] res_status;
    } t_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              full;
        logic              count_zero;
        logic              pos_zero;
        logic              pos_one;
        logic              pos_ge_count;
        logic              pos_gt_count;
        logic              walk_last;
        logic              read_last;
        logic              out_free;
    } t_stat;

endpackage

/* design/positional_linked_list.sv */
// Flow: a request is decided after acceptance; inserts that land at the head or tail and errors then
// give their registered result, and read-out gives its elements; inserts inside the list first walk
// to the position, then write the new node and relink it, and deletes past the head walk and unlink.
// Throughput: one request at a time; the walk follows one link per cycle, and read-out gives one
// element per cycle while the receiver takes each one.
// Reset (synchronous, active low) empties the list and frees all nodes; no clearing pass.
module positional_linked_list #(
    parameter int CAPACITY = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // func [2:0], position [10:3], value [42:11], unused [47:43]
    input  logic [pll_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // status [1:0], length [8:2], element [40:9], zero fill [47:41]
    output logic [pll_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    output logic                               o_m_tlast
);

    localparam int FUNC_LO = 0;
    localparam int POS_LO  = FUNC_LO + pll_pkg::FUNC_W;
    localparam int VAL_LO  = POS_LO + pll_pkg::POS_W;
    localparam int OUT_USED = pll_pkg::STATUS_W + pll_pkg::LEN_W + pll_pkg::VALUE_W;

    pll_pkg::t_cmd  cmd;
    pll_pkg::t_stat stat;

    logic [pll_pkg::FUNC_W-1:0]   req_func;
    logic [pll_pkg::POS_W-1:0]    req_pos;
    logic [pll_pkg::VALUE_W-1:0]  req_value;
    logic [pll_pkg::STATUS_W-1:0] res_status;
    logic [pll_pkg::LEN_W-1:0]    res_length;
    logic [pll_pkg::VALUE_W-1:0]  res_element;

    // Unpack the request fields.
    assign req_func  = i_s_tdata[FUNC_LO +: pll_pkg::FUNC_W];
    assign req_pos   = i_s_tdata[POS_LO +: pll_pkg::POS_W];
    assign req_value = i_s_tdata[VAL_LO +: pll_pkg::VALUE_W];

    // Pack the result fields.
    assign o_m_tdata = {(pll_pkg::OUT_TDATA_W - OUT_USED)'(0), res_element, res_length,
                        res_status};

    pll_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pll_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_func     (req_func),
        .i_pos      (req_pos),
        .i_value    (req_value),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_status   (res_status),
        .o_length   (res_length),
        .o_element  (res_element),
        .o_last     (o_m_tlast)
    );

endmodule

/* design/pll_ram.sv */
module pll_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/pll_datapath.sv */
`include "positional_linked_list_macros.svh"

module pll_datapath #(
    parameter int CAPACITY = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [pll_pkg::FUNC_W-1:0]      i_func,
    input  logic [pll_pkg::POS_W-1:0]       i_pos,
    input  logic signed [pll_pkg::VALUE_W-1:0] i_value,
    input  pll_pkg::t_cmd                   i_cmd,
    output pll_pkg::t_stat                  o_stat,
    input  logic                            i_m_tready,
    output logic                            o_m_tvalid,
    output logic [pll_pkg::STATUS_W-1:0]    o_status,
    output logic [pll_pkg::LEN_W-1:0]       o_length,
    output logic signed [pll_pkg::VALUE_W-1:0] o_element,
    output logic                            o_last
);

    localparam int PW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    // Latched request.
    logic [pll_pkg::FUNC_W-1:0]  r_func;
    logic [pll_pkg::POS_W-1:0]   r_pos;
    logic [pll_pkg::VALUE_W-1:0] r_value;

    // List state.
    logic [PW-1:0]       r_head, n_head;
    logic [PW-1:0]       r_tail, n_tail;
    logic [CW-1:0]       r_count, n_count;
    logic [CAPACITY-1:0] r_free, n_free;

    // Walk state.
    logic [PW-1:0] r_cur, n_cur;
    logic [PW-1:0] r_prev;
    logic [PW-1:0] r_node;
    logic [CW-1:0] r_steps;
    logic [CW-1:0] r_target;
    logic [CW-1:0] steps_inc;

    // Output register.
    logic                            r_out_valid;
    logic [pll_pkg::STATUS_W-1:0]    r_out_status;
    logic [pll_pkg::LEN_W-1:0]       r_out_len;
    logic [pll_pkg::VALUE_W-1:0]     r_out_elem;
    logic                            r_out_last;
    logic                            out_free;

    // Memory ports.
    logic [PW-1:0]               free_idx;
    logic                        lnk_we;
    logic [PW-1:0]               lnk_waddr;
    logic [PW-1:0]               lnk_wdata;
    logic [PW-1:0]               lnk_rdata;
    logic                        val_we;
    logic [pll_pkg::VALUE_W-1:0] val_rdata;

    assign out_free  = !r_out_valid || i_m_tready;
    assign steps_inc = CW'(r_steps + 1'b1);

    // Lowest-numbered free node.
    always_comb begin
        free_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (r_free[i]) begin
                free_idx = PW'(i);
            end
        end
    end

    // The read address follows the next walk pointer, so the read data
    // always holds the entries of the current node.
    always_comb begin
        if (i_cmd.load_req) begin
            n_cur = r_head;
        end else if (i_cmd.advance) begin
            n_cur = lnk_rdata;
        end else begin
            n_cur = r_cur;
        end
    end

    // List updates.
    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_free    = r_free;
        lnk_we    = 1'b0;
        lnk_waddr = '0;
        lnk_wdata = '0;
        val_we    = 1'b0;
        case (i_cmd.act)
            pll_pkg::ACT_INS_HEAD: begin
                val_we    = 1'b1;
                lnk_we    = 1'b1;
                lnk_waddr = free_idx;
                lnk_wdata = r_head;
                if (r_count == '0) begin
                    n_tail = free_idx;
                end
                n_head           = free_idx;
                n_count          = CW'(r_count + 1'b1);
                n_free[free_idx] = 1'b0;
            end
            pll_pkg::ACT_INS_TAIL: begin
                val_we = 1'b1;
                if (r_count == '0) begin
                    n_head = free_idx;
                end else begin
                    lnk_we    = 1'b1;
                    lnk_waddr = r_tail;
                    lnk_wdata = free_idx;
                end
                n_tail           = free_idx;
                n_count          = CW'(r_count + 1'b1);
                n_free[free_idx] = 1'b0;
            end
            pll_pkg::ACT_MID_NEW: begin
                val_we           = 1'b1;
                lnk_we           = 1'b1;
                lnk_waddr        = free_idx;
                lnk_wdata        = r_cur;
                n_count          = CW'(r_count + 1'b1);
                n_free[free_idx] = 1'b0;
            end
            pll_pkg::ACT_MID_LINK: begin
                lnk_we    = 1'b1;
                lnk_waddr = r_prev;
                lnk_wdata = r_node;
            end
            pll_pkg::ACT_DEL_HEAD: begin
                if (r_count == CW'(1)) begin
                    n_head = '0;
                    n_tail = '0;
                end else begin
                    n_head = lnk_rdata;
                end
                n_free[r_cur] = 1'b1;
                n_count       = CW'(r_count - 1'b1);
            end
            pll_pkg::ACT_DEL_MID: begin
                lnk_we    = 1'b1;
                lnk_waddr = r_prev;
                lnk_wdata = lnk_rdata;
                if (r_cur == r_tail) begin
                    n_tail = r_prev;
                end
                n_free[r_cur] = 1'b1;
                n_count       = CW'(r_count - 1'b1);
            end
            default: begin
            end
        endcase
    end

    // List state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_free  <= '1;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_free  <= n_free;
        end
    end

    // Request latch and walk registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur    <= '0;
            r_prev   <= '0;
            r_steps  <= '0;
            r_target <= '0;
        end else begin
            r_cur <= n_cur;
            if (i_cmd.advance) begin
                r_prev  <= r_cur;
                r_steps <= steps_inc;
            end
            if (i_cmd.walk_start) begin
                r_steps  <= '0;
                r_target <= i_cmd.tgt_minus1 ? CW'(r_pos - 1'b1) : CW'(r_pos);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_func  <= i_func;
            r_pos   <= i_pos;
            r_value <= i_value;
        end
        if (i_cmd.act == pll_pkg::ACT_MID_NEW) begin
            r_node <= free_idx;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_elem || i_cmd.emit_res) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_elem) begin
            r_out_status <= pll_pkg::ST_OK;
            r_out_len    <= pll_pkg::LEN_W'(r_count);
            r_out_elem   <= val_rdata;
            r_out_last   <= (steps_inc == r_count);
        end else if (i_cmd.emit_res) begin
            r_out_status <= i_cmd.res_status;
            r_out_len    <= pll_pkg::LEN_W'(r_count);
            r_out_elem   <= '0;
            r_out_last   <= 1'b1;
        end
    end

    // Node stores.
    pll_ram #(
        .WIDTH (PW),
        .DEPTH (CAPACITY)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (lnk_we),
        .i_waddr (lnk_waddr),
        .i_wdata (lnk_wdata),
        .i_raddr (n_cur),
        .o_rdata (lnk_rdata)
    );

    pll_ram #(
        .WIDTH (pll_pkg::VALUE_W),
        .DEPTH (CAPACITY)
    ) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (free_idx),
        .i_wdata (r_value),
        .i_raddr (n_cur),
        .o_rdata (val_rdata)
    );

    // Status toward the controller.
    always_comb begin
        o_stat.func         = r_func;
        o_stat.full         = (r_count == CW'(CAPACITY));
        o_stat.count_zero   = (r_count == '0);
        o_stat.pos_zero     = (r_pos == '0);
        o_stat.pos_one      = (r_pos == pll_pkg::POS_W'(1));
        o_stat.pos_ge_count = (r_pos >= pll_pkg::POS_W'(r_count));
        o_stat.pos_gt_count = (r_pos > pll_pkg::POS_W'(r_count));
        o_stat.walk_last    = (steps_inc == r_target);
        o_stat.read_last    = (steps_inc == r_count);
        o_stat.out_free     = out_free;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_status   = r_out_status;
    assign o_length   = r_out_len;
    assign o_element  = r_out_elem;
    assign o_last     = r_out_last;

    // Every node is either free or on the list.
    `PLL_ASSERT(a_pool_balance, $countones(r_free) + int'(r_count) == CAPACITY, "node pool out of balance")
    // A result is only loaded when the output register can take it.
    `PLL_ASSERT_IMP(a_emit_free, i_cmd.emit_elem || i_cmd.emit_res, out_free, "result overwrote a pending one")

endmodule

/* design/pll_ctrl.sv */
`include "positional_linked_list_macros.svh"

module pll_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  pll_pkg::t_stat i_stat,
    output pll_pkg::t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_WALK   = 3'd2;
    localparam logic [2:0] S_MID1   = 3'd3;
    localparam logic [2:0] S_MID2   = 3'd4;
    localparam logic [2:0] S_DELM   = 3'd5;
    localparam logic [2:0] S_READ   = 3'd6;
    localparam logic [2:0] S_RESULT = 3'd7;

    logic [2:0]                   r_state, n_state;
    logic [pll_pkg::STATUS_W-1:0] r_status, n_status;

    assign o_s_tready = (r_state == S_IDLE);

    // Sequencing of one request.
    always_comb begin
        o_cmd    = '0;
        n_state  = r_state;
        n_status = r_status;
        case (r_state)
            S_IDLE: begin
                o_cmd.load_req = i_s_tvalid;
                if (i_s_tvalid) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_status = pll_pkg::ST_OK;
                n_state  = S_RESULT;
                case (i_stat.func)
                    pll_pkg::FUNC_INS_HEAD, pll_pkg::FUNC_INS_TAIL,
                    pll_pkg::FUNC_INS_POS: begin
                        if (i_stat.full) begin
                            n_status = pll_pkg::ST_FULL;
                        end else if (i_stat.func == pll_pkg::FUNC_INS_HEAD ||
                                     (i_stat.func == pll_pkg::FUNC_INS_POS &&
                                      i_stat.pos_zero)) begin
                            o_cmd.act = pll_pkg::ACT_INS_HEAD;
                        end else if (i_stat.func == pll_pkg::FUNC_INS_TAIL ||
                                     i_stat.pos_ge_count) begin
                            o_cmd.act = pll_pkg::ACT_INS_TAIL;
                        end else begin
                            o_cmd.walk_start = 1'b1;
                            n_state          = S_WALK;
                        end
                    end
                    pll_pkg::FUNC_DELETE: begin
                        if (i_stat.count_zero) begin
                            n_status = pll_pkg::ST_EMPTY;
                        end else if (i_stat.pos_zero || i_stat.pos_gt_count) begin
                            n_status = pll_pkg::ST_BAD_POS;
                        end else if (i_stat.pos_one) begin
                            o_cmd.act = pll_pkg::ACT_DEL_HEAD;
                        end else begin
                            o_cmd.walk_start = 1'b1;
                            o_cmd.tgt_minus1 = 1'b1;
                            n_state          = S_WALK;
                        end
                    end
                    pll_pkg::FUNC_READ_ALL: begin
                        if (!i_stat.count_zero) begin
                            o_cmd.walk_start = 1'b1;
                            n_state          = S_READ;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_WALK: begin
                o_cmd.advance = 1'b1;
                if (i_stat.walk_last) begin
                    n_state = (i_stat.func == pll_pkg::FUNC_INS_POS) ? S_MID1 : S_DELM;
                end
            end
            S_MID1: begin
                o_cmd.act = pll_pkg::ACT_MID_NEW;
                n_state   = S_MID2;
            end
            S_MID2: begin
                o_cmd.act = pll_pkg::ACT_MID_LINK;
                n_state   = S_RESULT;
            end
            S_DELM: begin
                o_cmd.act = pll_pkg::ACT_DEL_MID;
                n_state   = S_RESULT;
            end
            S_READ: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_elem = 1'b1;
                    o_cmd.advance   = 1'b1;
                    if (i_stat.read_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_RESULT: begin
                o_cmd.res_status = r_status;
                if (i_stat.out_free) begin
                    o_cmd.emit_res = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= pll_pkg::ST_OK;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

    // Only position inserts and deletes walk the list.
    `PLL_ASSERT_IMP(a_walk_func, r_state == S_WALK, i_stat.func == pll_pkg::FUNC_INS_POS || i_stat.func == pll_pkg::FUNC_DELETE, "walk for a request that needs none")
    // A read-out runs only over a non-empty list.
    `PLL_ASSERT_IMP(a_read_nonempty, r_state == S_READ, !i_stat.count_zero, "read-out of an empty list")

endmodule

/* test/positional_linked_list_tb.sv */
`timescale 1ns / 100ps

module positional_linked_list_tb;

    localparam int CAPACITY     = 32;
    localparam int IDLE_LIMIT   = 3000;
    localparam int LONG_HOLD    = 200;
    localparam int QUIET_ITEMS  = 25;
    localparam int SETTLE_TICKS = 50;

    // Operation codes that the block leaves unused.
    localparam logic [pll_pkg::FUNC_W-1:0] FUNC_SPARE_LO  = 3'd5;
    localparam logic [pll_pkg::FUNC_W-1:0] FUNC_SPARE_MID = 3'd6;
    localparam logic [pll_pkg::FUNC_W-1:0] FUNC_SPARE_HI  = 3'd7;

    // One request as the stimulus generator queues it.
    typedef struct {
        logic [pll_pkg::FUNC_W-1:0]  func;
        logic [pll_pkg::POS_W-1:0]   pos;
        logic [pll_pkg::VALUE_W-1:0] value;
        logic                        wait_idle;
    } t_list_req;

    // One result as the block should report it.
    typedef struct packed {
        logic [pll_pkg::STATUS_W-1:0] status;
        logic [pll_pkg::LEN_W-1:0]    length;
        logic [pll_pkg::VALUE_W-1:0]  element;
        logic                         last;
    } t_list_result;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [pll_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [pll_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                            m_tlast;

    t_list_req                   pending_reqs[$];
    t_list_result                expected_results[$];
    logic [pll_pkg::VALUE_W-1:0] list_vals[$];

    int   gen_len = 0;
    int   total_items = 0;
    int   accepted_reqs = 0;
    int   mismatch_count = 0;
    int   idle_cycles = 0;
    int   hold_cnt = 0;
    int   stall_cnt = 0;
    int   gap_cnt = 0;
    logic hold_done = 1'b0;
    logic req_fire = 1'b0;
    logic quiet_tail;

    assign quiet_tail = (total_items > 0) && (accepted_reqs + QUIET_ITEMS >= total_items);

    positional_linked_list #(
        .CAPACITY(CAPACITY)
    ) u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    // Print one mismatch line and count it.
    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t ERROR %s: got %0h, expected %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Apply one request to the list image and queue the results it causes.
    task automatic model_list_request(input logic [pll_pkg::FUNC_W-1:0] func,
                                      input logic [pll_pkg::POS_W-1:0] pos,
                                      input logic [pll_pkg::VALUE_W-1:0] value);
        int           cnt;
        t_list_result res;
        cnt = list_vals.size();
        res.status  = pll_pkg::ST_OK;
        res.element = '0;
        res.last    = 1'b1;
        case (func)
            pll_pkg::FUNC_INS_HEAD, pll_pkg::FUNC_INS_TAIL, pll_pkg::FUNC_INS_POS: begin
                if (cnt >= CAPACITY) begin
                    res.status = pll_pkg::ST_FULL;
                end else if (func == pll_pkg::FUNC_INS_HEAD ||
                             (func == pll_pkg::FUNC_INS_POS && pos == 0)) begin
                    list_vals.push_front(value);
                end else if (func == pll_pkg::FUNC_INS_TAIL || int'(pos) >= cnt) begin
                    list_vals.push_back(value);
                end else begin
                    list_vals.insert(int'(pos), value);
                end
            end
            pll_pkg::FUNC_DELETE: begin
                if (cnt == 0) begin
                    res.status = pll_pkg::ST_EMPTY;
                end else if (pos == 0 || int'(pos) > cnt) begin
                    res.status = pll_pkg::ST_BAD_POS;
                end else begin
                    list_vals.delete(int'(pos) - 1);
                end
            end
            pll_pkg::FUNC_READ_ALL: begin
                // A non-empty list reads out one result per element.
                if (cnt > 0) begin
                    for (int i = 0; i < cnt; i++) begin
                        res.length  = pll_pkg::LEN_W'(cnt);
                        res.element = list_vals[i];
                        res.last    = (i == cnt - 1);
                        expected_results.push_back(res);
                    end
                    return;
                end
            end
            default: ;
        endcase
        res.length = pll_pkg::LEN_W'(list_vals.size());
        expected_results.push_back(res);
    endtask

    // Queue a request and track the list length the block will reach.
    task automatic add_req(input logic [pll_pkg::FUNC_W-1:0] func, input int pos,
                           input logic [pll_pkg::VALUE_W-1:0] value, input logic wait_idle);
        t_list_req req;
        req.func      = func;
        req.pos       = pll_pkg::POS_W'(pos);
        req.value     = value;
        req.wait_idle = wait_idle;
        pending_reqs.push_back(req);
        if (func == pll_pkg::FUNC_INS_HEAD || func == pll_pkg::FUNC_INS_TAIL ||
            func == pll_pkg::FUNC_INS_POS) begin
            if (gen_len < CAPACITY) gen_len++;
        end else if (func == pll_pkg::FUNC_DELETE) begin
            if (gen_len > 0 && req.pos >= 1 && int'(req.pos) <= gen_len) gen_len--;
        end
    endtask

    function automatic logic [pll_pkg::FUNC_W-1:0] pick_ins_func();
        case ($urandom_range(0, 2))
            0:       return pll_pkg::FUNC_INS_HEAD;
            1:       return pll_pkg::FUNC_INS_TAIL;
            default: return pll_pkg::FUNC_INS_POS;
        endcase
    endfunction

    // Mostly a position inside the list, sometimes anywhere in the field.
    function automatic int pick_ins_pos();
        if ($urandom_range(0, 3) == 0) return $urandom_range(0, 255);
        return $urandom_range(0, gen_len);
    endfunction

    function automatic int pick_del_pos();
        if ($urandom_range(0, 5) == 0 || gen_len == 0) return $urandom_range(0, 255);
        return $urandom_range(1, gen_len);
    endfunction

    // One random request with the given share of inserts in percent.
    task automatic add_random_req(input int ins_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < ins_pct)
            add_req(pick_ins_func(), pick_ins_pos(), $urandom(), 1'b0);
        else if (r < ins_pct + 8)
            add_req(pll_pkg::FUNC_READ_ALL, $urandom_range(0, 255), $urandom(), 1'b0);
        else if (r < ins_pct + 12)
            add_req(pll_pkg::FUNC_W'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI)),
                    $urandom_range(0, 255), $urandom(), 1'b0);
        else
            add_req(pll_pkg::FUNC_DELETE, pick_del_pos(), $urandom(), 1'b0);
    endtask

    // Request driver: presents queued requests at the falling edge.
    always @(negedge clk) begin : req_driver
        t_list_req nxt;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || req_fire) begin
            if (gap_cnt > 0) begin
                gap_cnt--;
                s_tvalid <= 1'b0;
            end else if (pending_reqs.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (pending_reqs[0].wait_idle && expected_results.size() != 0) begin
                s_tvalid <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
                gap_cnt = $urandom_range(0, 3);
                s_tvalid <= 1'b0;
            end else begin
                nxt = pending_reqs.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {5'b0, nxt.value, nxt.pos, nxt.func};
            end
        end
    end

    // Result receiver: random stalls plus one long hold once 50 requests are accepted.
    always @(negedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt--;
            m_tready <= 1'b0;
        end else if (!hold_done && accepted_reqs >= 50) begin
            hold_done = 1'b1;
            hold_cnt  = LONG_HOLD - 1;
            m_tready <= 1'b0;
        end else if (stall_cnt > 0) begin
            stall_cnt--;
            m_tready <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            stall_cnt = $urandom_range(0, 3);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Monitor: checks results, predicts accepted requests, and watches for a hang.
    always @(posedge clk) begin : monitor
        t_list_result seen;
        t_list_result want;
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                seen.status  = m_tdata[1:0];
                seen.length  = m_tdata[8:2];
                seen.element = m_tdata[40:9];
                seen.last    = m_tlast;
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing expected", seen, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (seen.status != want.status)
                        report_mismatch("status", seen.status, want.status);
                    if (seen.length != want.length)
                        report_mismatch("length", seen.length, want.length);
                    if (seen.element != want.element)
                        report_mismatch("element", seen.element, want.element);
                    if (seen.last != want.last)
                        report_mismatch("last", seen.last, want.last);
                end
            end
            if (s_tvalid && s_tready) begin
                model_list_request(s_tdata[2:0], s_tdata[10:3], s_tdata[42:11]);
                accepted_reqs++;
            end
            req_fire <= s_tvalid && s_tready;
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        // Directed part: empty list, lone node, every insert kind, bad deletes.
        add_req(pll_pkg::FUNC_READ_ALL, 0, 32'h0, 1'b0);
        add_req(pll_pkg::FUNC_DELETE, 1, 32'h0, 1'b0);
        add_req(FUNC_SPARE_LO, 0, 32'h0, 1'b0);
        add_req(pll_pkg::FUNC_INS_HEAD, 0, 32'h7fff_ffff, 1'b0);
        add_req(pll_pkg::FUNC_DELETE, 2, 32'h0, 1'b0);
        add_req(pll_pkg::FUNC_DELETE, 0, 32'h0, 1'b0);
        add_req(pll_pkg::FUNC_DELETE, 1, 32'h0, 1'b0);
        add_req(pll_pkg::FUNC_INS_TAIL, 0, 32'h8000_0000, 1'b0);
        add_req(pll_pkg::FUNC_INS_POS, 0, 32'hffff_ffff, 1'b0);
        add_req(pll_pkg::FUNC_INS_POS, 255, 32'h0, 1'b0);
        add_req(pll_pkg::FUNC_INS_POS, 1, 32'h1, 1'b0);
        add_req(pll_pkg::FUNC_INS_POS, 3, 32'h1234_5678, 1'b0);
        add_req(pll_pkg::FUNC_INS_POS, 5, 32'h55aa_55aa, 1'b0);
        add_req(pll_pkg::FUNC_READ_ALL, 255, 32'hffff_ffff, 1'b0);
        add_req(pll_pkg::FUNC_DELETE, 255, 32'h0, 1'b0);
        add_req(pll_pkg::FUNC_DELETE, 7, 32'h0, 1'b0);
        add_req(pll_pkg::FUNC_DELETE, 6, 32'h0, 1'b0);
        add_req(pll_pkg::FUNC_DELETE, 3, 32'h0, 1'b0);
        add_req(pll_pkg::FUNC_DELETE, 1, 32'h0, 1'b0);
        add_req(FUNC_SPARE_MID, 0, 32'h0, 1'b0);
        add_req(FUNC_SPARE_HI, 255, 32'hffff_ffff, 1'b0);
        add_req(pll_pkg::FUNC_READ_ALL, 0, 32'h0, 1'b0);
        add_req(pll_pkg::FUNC_INS_HEAD, 255, 32'h0, 1'b0);

        // Fill the pool past full, then a mix leaning on inserts.
        repeat (30) add_req(pick_ins_func(), pick_ins_pos(), $urandom(), 1'b0);
        repeat (15) add_random_req(70);

        // After the block drains, empty the list through valid deletes.
        add_req(pll_pkg::FUNC_READ_ALL, $urandom_range(0, 255), $urandom(), 1'b1);
        repeat (34) begin
            if (gen_len > 0)
                add_req(pll_pkg::FUNC_DELETE, $urandom_range(1, gen_len), $urandom(), 1'b0);
            else
                add_req(pll_pkg::FUNC_DELETE, $urandom_range(0, 255), $urandom(), 1'b0);
        end
        repeat (6) add_random_req(20);

        // Balanced mix, the last stretch of it without idling.
        add_req(pll_pkg::FUNC_INS_TAIL, 0, $urandom(), 1'b1);
        repeat (20) add_random_req(45);

        total_items = pending_reqs.size();

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_reqs.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);

        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
